@@ design/assert_macros.svh @@
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMP(lbl, ante, cons, msg)
`define AST_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/lzw_enc_pkg.sv @@
package lzw_enc_pkg;

  localparam int MAX_CODE_BITS = 12;
  localparam int TABLE_SIZE    = 1 << MAX_CODE_BITS;
  localparam int NFC_W         = MAX_CODE_BITS + 1;
  localparam int W_W           = $clog2(MAX_CODE_BITS + 1);
  localparam int ACC_W         = 7 + MAX_CODE_BITS;
  localparam int CNT_W         = $clog2(ACC_W + 1);
  localparam int PAIR_W        = MAX_CODE_BITS + 8;

  localparam logic [MAX_CODE_BITS-1:0] CLR_CODE   = MAX_CODE_BITS'(256);
  localparam logic [MAX_CODE_BITS-1:0] END_CODE   = MAX_CODE_BITS'(257);
  localparam logic [NFC_W-1:0]         FIRST_FREE = NFC_W'(258);
  localparam logic [W_W-1:0]           START_W    = W_W'(9);
  localparam logic [W_W-1:0]           MAX_W      = W_W'(MAX_CODE_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_CLR_START, S_SET_STR, S_SRCH0, S_SRCH, S_UPDATE,
    S_LAST_CHK, S_EMIT_EOI, S_FLUSH, S_CLOSE, S_PUT, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    SEL_CLR, SEL_EOI, SEL_STR
  } code_sel_t;

  typedef struct packed {
    logic      latch;
    logic      start;
    logic      load;
    code_sel_t sel;
    logic      set_str_byte;
    logic      set_str_found;
    logic      open_set;
    logic      close;
    logic      srch_init;
    logic      srch_run;
    logic      add_entry;
    logic      restart;
    logic      flush;
    logic      put;
    logic      fin_push;
  } dp_cmd_t;

  typedef struct packed {
    logic is_new;
    logic empty;
    logic last;
    logic hit;
    logic miss;
    logic room;
    logic more;
    logic hold_v;
    logic out_free;
  } dp_sts_t;

endpackage

@@ design/lzw_enc_ram.sv @@
module lzw_enc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/lzw_enc_dp.sv @@
`include "assert_macros.svh"

module lzw_enc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_tdata,
  input  logic                in_tlast,
  input  logic [1:0]          in_tuser,
  input  lzw_enc_pkg::dp_cmd_t cmd,
  output lzw_enc_pkg::dp_sts_t sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);
  import lzw_enc_pkg::*;

  logic [7:0]               byte_r, byte_nxt;
  logic                     first_r, first_nxt, last_r, last_nxt, empty_r, empty_nxt;
  logic                     ended_r, ended_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [W_W-1:0]           width_r, width_nxt;
  logic [NFC_W-1:0]         nfc_r, nfc_nxt;
  logic [MAX_CODE_BITS-1:0] str_r, str_nxt;
  logic                     open_r, open_nxt;
  logic [NFC_W-1:0]         scan_r, scan_nxt;
  logic                     cmp_v_r, cmp_v_nxt;
  logic [MAX_CODE_BITS-1:0] cmp_addr_r, cmp_addr_nxt;
  logic [7:0]               hold_r, hold_nxt;
  logic                     hold_v_r, hold_v_nxt;
  logic                     out_v_r, out_v_nxt;
  logic [7:0]               out_d_r, out_d_nxt;
  logic                     out_li_r, out_li_nxt, out_eos_r, out_eos_nxt;

  logic [PAIR_W-1:0]        pair, rdata;
  logic                     we;
  logic [W_W-1:0]           w_use;
  logic [MAX_CODE_BITS-1:0] code_raw, code_m;
  logic [NFC_W-1:0]         mask_w, nfc_inc;
  logic [ACC_W-1:0]         res_m, res_base;
  logic [CNT_W-1:0]         cnt_base;
  logic [7:0]               new_byte;
  logic                     out_free;

  assign pair     = {str_r, byte_r};
  assign out_free = !out_v_r || out_tready;
  assign res_m    = acc_r & ((ACC_W'(1) << cnt_r) - ACC_W'(1));
  assign w_use    = cmd.start ? START_W : width_r;
  assign mask_w   = (NFC_W'(1) << w_use) - NFC_W'(1);
  assign nfc_inc  = nfc_r + NFC_W'(1);
  assign new_byte = 8'(acc_r >> (cnt_r - CNT_W'(8)));

  always_comb begin
    unique case (cmd.sel)
      SEL_CLR: code_raw = CLR_CODE;
      SEL_EOI: code_raw = END_CODE;
      SEL_STR: code_raw = str_r;
      default: code_raw = str_r;
    endcase
    code_m   = code_raw & mask_w[MAX_CODE_BITS-1:0];
    res_base = cmd.start ? '0 : res_m;
    cnt_base = cmd.start ? '0 : cnt_r;
  end

  always_comb begin
    byte_nxt     = byte_r;
    first_nxt    = first_r;
    last_nxt     = last_r;
    empty_nxt    = empty_r;
    ended_nxt    = ended_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    width_nxt    = width_r;
    nfc_nxt      = nfc_r;
    str_nxt      = str_r;
    open_nxt     = open_r;
    scan_nxt     = scan_r;
    cmp_v_nxt    = cmp_v_r;
    cmp_addr_nxt = cmp_addr_r;
    hold_nxt     = hold_r;
    hold_v_nxt   = hold_v_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_d_nxt    = out_d_r;
    out_li_nxt   = out_li_r;
    out_eos_nxt  = out_eos_r;
    we           = 1'b0;

    if (cmd.latch) begin
      byte_nxt  = in_tdata;
      last_nxt  = in_tlast;
      first_nxt = in_tuser[0];
      empty_nxt = in_tuser[1];
      ended_nxt = 1'b0;
    end
    if (cmd.start || cmd.restart) begin
      nfc_nxt   = FIRST_FREE;
      width_nxt = START_W;
    end
    if (cmd.load) begin
      acc_nxt = (res_base << w_use) | ACC_W'(code_m);
      cnt_nxt = cnt_base + CNT_W'(w_use);
    end
    if (cmd.set_str_byte) begin
      str_nxt = MAX_CODE_BITS'(byte_r);
    end
    if (cmd.set_str_found) begin
      str_nxt = cmp_addr_r;
    end
    if (cmd.open_set) begin
      open_nxt = 1'b1;
    end
    if (cmd.close) begin
      str_nxt   = '0;
      open_nxt  = 1'b0;
      ended_nxt = 1'b1;
    end
    if (cmd.srch_init) begin
      scan_nxt  = FIRST_FREE;
      cmp_v_nxt = 1'b0;
    end
    if (cmd.srch_run) begin
      if (scan_r < nfc_r) begin
        scan_nxt     = scan_r + NFC_W'(1);
        cmp_v_nxt    = 1'b1;
        cmp_addr_nxt = scan_r[MAX_CODE_BITS-1:0];
      end else begin
        cmp_v_nxt = 1'b0;
      end
    end
    if (cmd.add_entry) begin
      we      = 1'b1;
      nfc_nxt = nfc_inc;
      if (nfc_inc > (NFC_W'(1) << width_r) && width_r < MAX_W) begin
        width_nxt = width_r + W_W'(1);
      end
    end
    if (cmd.flush && cnt_r != '0) begin
      acc_nxt = res_m << (CNT_W'(8) - cnt_r);
      cnt_nxt = CNT_W'(8);
    end
    if (cmd.put) begin
      cnt_nxt    = cnt_r - CNT_W'(8);
      hold_nxt   = new_byte;
      hold_v_nxt = 1'b1;
      if (hold_v_r) begin
        out_v_nxt   = 1'b1;
        out_d_nxt   = hold_r;
        out_li_nxt  = 1'b0;
        out_eos_nxt = 1'b0;
      end
    end
    if (cmd.fin_push) begin
      hold_v_nxt  = 1'b0;
      out_v_nxt   = 1'b1;
      out_d_nxt   = hold_r;
      out_li_nxt  = 1'b1;
      out_eos_nxt = ended_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ended_r  <= 1'b0;
      acc_r    <= '0;
      cnt_r    <= '0;
      width_r  <= START_W;
      nfc_r    <= FIRST_FREE;
      str_r    <= '0;
      open_r   <= 1'b0;
      cmp_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      ended_r  <= ended_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      width_r  <= width_nxt;
      nfc_r    <= nfc_nxt;
      str_r    <= str_nxt;
      open_r   <= open_nxt;
      cmp_v_r  <= cmp_v_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    empty_r    <= empty_nxt;
    scan_r     <= scan_nxt;
    cmp_addr_r <= cmp_addr_nxt;
    hold_r     <= hold_nxt;
    out_d_r    <= out_d_nxt;
    out_li_r   <= out_li_nxt;
    out_eos_r  <= out_eos_nxt;
  end

  // dictionary of prefix code and byte pairs
  lzw_enc_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(TABLE_SIZE)
  ) u_dict (
    .clk  (clk),
    .we   (we),
    .waddr(nfc_r[MAX_CODE_BITS-1:0]),
    .wdata(pair),
    .raddr(scan_r[MAX_CODE_BITS-1:0]),
    .rdata(rdata)
  );

  always_comb begin
    sts.is_new   = empty_r || first_r || !open_r;
    sts.empty    = empty_r;
    sts.last     = last_r;
    sts.hit      = cmp_v_r && (rdata == pair);
    sts.miss     = !cmp_v_r && (scan_r >= nfc_r);
    sts.room     = nfc_r < NFC_W'(TABLE_SIZE);
    sts.more     = cnt_r >= CNT_W'(8);
    sts.hold_v   = hold_v_r;
    sts.out_free = out_free;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_eos_r;
  assign out_tuser  = out_li_r;

  `AST_IMP(a_width_range, 1'b1, width_r >= START_W && width_r <= MAX_W, "code width out of range")
  `AST_IMP(a_nfc_range, 1'b1, nfc_r >= FIRST_FREE && nfc_r <= NFC_W'(TABLE_SIZE), "free code out of range")
  `AST_IMP(a_hit_miss, sts.hit, !sts.miss, "search hit and miss at once")
  `AST_NXT(a_put_fills_hold, cmd.put, hold_v_r, "put left hold empty")

endmodule

@@ design/lzw_enc_ctrl.sv @@
module lzw_enc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  lzw_enc_pkg::dp_sts_t sts,
  output lzw_enc_pkg::dp_cmd_t cmd
);
  import lzw_enc_pkg::*;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    unique case (state_r)
      S_IDLE:      if (in_tvalid) state_nxt = S_DECIDE;
      S_DECIDE:    state_nxt = sts.is_new ? S_CLR_START : S_SRCH0;
      S_CLR_START: begin
        ret_nxt   = sts.empty ? S_EMIT_EOI : S_SET_STR;
        state_nxt = S_PUT;
      end
      S_SET_STR:   state_nxt = S_LAST_CHK;
      S_SRCH0:     state_nxt = S_SRCH;
      S_SRCH: begin
        if (sts.hit) begin
          state_nxt = S_LAST_CHK;
        end else if (sts.miss) begin
          ret_nxt   = S_UPDATE;
          state_nxt = S_PUT;
        end
      end
      S_UPDATE: begin
        if (sts.room) begin
          state_nxt = S_LAST_CHK;
        end else begin
          ret_nxt   = S_LAST_CHK;
          state_nxt = S_PUT;
        end
      end
      S_LAST_CHK: begin
        if (sts.last) begin
          ret_nxt   = S_EMIT_EOI;
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EMIT_EOI: begin
        ret_nxt   = S_FLUSH;
        state_nxt = S_PUT;
      end
      S_FLUSH: begin
        ret_nxt   = S_CLOSE;
        state_nxt = S_PUT;
      end
      S_CLOSE:     state_nxt = S_FIN;
      S_PUT:       if (!sts.more) state_nxt = ret_r;
      S_FIN:       if (!sts.hold_v || sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.sel   = SEL_STR;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      S_CLR_START: begin
        cmd.start = 1'b1;
        cmd.load  = 1'b1;
        cmd.sel   = SEL_CLR;
      end
      S_SET_STR: begin
        cmd.set_str_byte = 1'b1;
        cmd.open_set     = 1'b1;
      end
      S_SRCH0: cmd.srch_init = 1'b1;
      S_SRCH: begin
        if (sts.hit) begin
          cmd.set_str_found = 1'b1;
        end else if (sts.miss) begin
          cmd.load = 1'b1;
        end else begin
          cmd.srch_run = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.set_str_byte = 1'b1;
        if (sts.room) begin
          cmd.add_entry = 1'b1;
        end else begin
          // table full: clear code at the old width, then restart
          cmd.load    = 1'b1;
          cmd.sel     = SEL_CLR;
          cmd.restart = 1'b1;
        end
      end
      S_LAST_CHK: cmd.load = sts.last;
      S_EMIT_EOI: begin
        cmd.load = 1'b1;
        cmd.sel  = SEL_EOI;
      end
      S_FLUSH:    cmd.flush = 1'b1;
      S_CLOSE:    cmd.close = 1'b1;
      S_PUT:      cmd.put = sts.more && (!sts.hold_v || sts.out_free);
      S_FIN:      cmd.fin_push = sts.hold_v && sts.out_free;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

@@ design/lzw_byte_stream_encoder_top.sv @@
// lzw encoder, one strip byte per item, code stream packed msb-first
// a continuing byte scans dictionary entries 258 to nfc - 1 until a hit,
// one entry per cycle through the single read port of the dictionary memory
// items: one item at a time, a new item is taken only after the last is done
// reset: synchronous active-low rst_n; dictionary contents are not cleared
module lzw_byte_stream_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tlast,   // last_of_strip
  input  logic [1:0] in_tuser,   // first_of_strip, empty_strip
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // code_byte
  output logic       out_tlast,  // end_of_strip
  output logic       out_tuser   // last_of_item
);
  import lzw_enc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  lzw_enc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzw_enc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 12;
  localparam int TBL = 1 << MAXW;
  localparam int TOP = TBL - 1;
  localparam logic [11:0] CLR = 12'd256;
  localparam logic [11:0] EOI = 12'd257;
  localparam int FREE0 = 258;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       end_of_strip;
  } code_out_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic       empty;
    int         nexp;     // -1: use predictor only
    logic [7:0] b0, b1, b2;
  } stim_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast, out_tvalid, out_tready, out_tlast, out_tuser;
  logic [7:0] in_tdata, out_tdata;
  logic [1:0] in_tuser;

  lzw_byte_stream_encoder_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  // predictor state
  logic [19:0] dict [TBL];
  int          nfc, cw, str_code;
  logic [31:0] residue;
  int          rcount;
  bit          str_open;
  code_out_t   exp_codes[$];
  code_out_t   step_codes[$];

  int  errors = 0, cycles = 0, outs = 0, items = 0, strips = 0;
  bit  sink_idle_on = 1;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic put_code_byte(input logic [7:0] b);
    code_out_t c;
    c.code_byte = b;
    c.last_of_item = 0;
    c.end_of_strip = 0;
    step_codes.insert(step_codes.size(), c);
  endtask

  task automatic pack_code(input int code);
    logic [31:0] acc;
    int n;
    acc = (residue << cw) | (code & ((1 << cw) - 1));
    n = rcount + cw;
    while (n >= 8) begin
      n -= 8;
      put_code_byte(8'(acc >> n));
    end
    residue = acc & ((32'd1 << n) - 1);
    rcount = n;
  endtask

  task automatic open_strip();
    nfc = FREE0;
    cw = 9;
    residue = 0;
    rcount = 0;
    pack_code(CLR);
  endtask

  task automatic close_strip();
    if (rcount > 0) begin
      put_code_byte(8'(residue << (8 - rcount)));
      residue = 0;
      rcount = 0;
    end
    str_code = 0;
    str_open = 0;
  endtask

  // encodes one item, leaves its bytes in step_codes
  task automatic encode_item(input logic [7:0] b, input logic first, input logic last,
                             input logic empty);
    logic [19:0] pair;
    int found;
    bit ended;
    ended = 0;
    step_codes.delete();
    if (empty) begin
      open_strip();
      pack_code(EOI);
      close_strip();
      ended = 1;
    end else begin
      if (first || !str_open) begin
        open_strip();
        str_code = b;
        str_open = 1;
      end else begin
        pair = {12'(str_code), b};
        found = -1;
        for (int c = FREE0; c < nfc && c < TBL; c++)
          if (dict[c] == pair) begin
            found = c;
            break;
          end
        if (found >= 0) begin
          str_code = found;
        end else begin
          pack_code(str_code);
          if (nfc <= TOP) begin
            dict[nfc] = pair;
            nfc++;
            if (nfc > (1 << cw) && cw < MAXW) cw++;
          end else begin
            pack_code(CLR);
            nfc = FREE0;
            cw = 9;
          end
          str_code = b;
        end
      end
      if (last) begin
        pack_code(str_code);
        pack_code(EOI);
        close_strip();
        ended = 1;
      end
    end
    if (step_codes.size() > 0) begin
      step_codes[$].last_of_item = 1;
      if (ended) step_codes[$].end_of_strip = 1;
    end
    if (ended) strips++;
  endtask

  // result checker and sink stall
  int sink_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        code_out_t e;
        outs <= outs + 1;
        if (exp_codes.size() == 0) begin
          $display("%0t: unexpected byte %h", $time, out_tdata);
          errors++;
        end else begin
          e = exp_codes.pop_front();
          if (e.code_byte !== out_tdata || e.last_of_item !== out_tuser ||
              e.end_of_strip !== out_tlast) begin
            $display("%0t: mismatch expected byte=%h item_end=%b strip_end=%b, got %h %b %b",
                     $time, e.code_byte, e.last_of_item, e.end_of_strip,
                     out_tdata, out_tuser, out_tlast);
            errors++;
          end
        end
      end
      if (sink_gap > 0 && sink_idle_on) begin
        sink_gap--;
        out_tready <= 0;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
        sink_gap = $urandom_range(1, 17);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // valid drops after each accept, and the block is busy then anyway
  task automatic send_item(input logic [7:0] b, input logic first, input logic last,
                           input logic empty, input bit idle_ok);
    if (idle_ok && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 17)) @(posedge clk);
    encode_item(b, first, last, empty);
    foreach (step_codes[i]) exp_codes.insert(exp_codes.size(), step_codes[i]);
    in_tvalid <= 1;
    in_tdata <= b;
    in_tlast <= last;
    in_tuser <= {empty, first};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_tvalid <= 0;
    items++;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (exp_codes.size() != 0) @(posedge clk);
  endtask

  stim_row_t rows[$];

  function automatic stim_row_t mk(input logic [7:0] b, input logic f, input logic l,
                                   input logic e, input int n, input logic [7:0] x0,
                                   input logic [7:0] x1, input logic [7:0] x2);
    stim_row_t r;
    r.data_byte = b; r.first = f; r.last = l; r.empty = e;
    r.nexp = n; r.b0 = x0; r.b1 = x1; r.b2 = x2;
    return r;
  endfunction

  initial begin
    logic [7:0] alpha;
    int len;
    in_tvalid = 0; in_tdata = 0; in_tlast = 0; in_tuser = 0;
    rst_n = 0;
    residue = 0; rcount = 0; nfc = FREE0; cw = 9; str_code = 0; str_open = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty strip: clear and eoi at width 9 -> 80 40 40 (flag bits ignored)
    rows.insert(rows.size(), mk(8'hff, 1, 1, 1, 3, 8'h80, 8'h40, 8'h40));
    // one-byte strip of 00: clear, 0, eoi, flush
    rows.insert(rows.size(), mk(8'h00, 1, 1, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'hff, 1, 1, 0, -1, 0, 0, 0));
    // byte with no strip open, then hits and misses
    rows.insert(rows.size(), mk(8'haa, 0, 0, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'haa, 0, 0, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'haa, 0, 0, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'haa, 0, 0, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'h55, 0, 0, 0, -1, 0, 0, 0));
    // restart while open, then empty while open
    rows.insert(rows.size(), mk(8'h01, 1, 0, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'h80, 0, 0, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'h00, 0, 0, 1, 3, 8'h80, 8'h40, 8'h40));
    rows.insert(rows.size(), mk(8'h7f, 1, 0, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'h7f, 0, 0, 0, -1, 0, 0, 0));
    rows.insert(rows.size(), mk(8'h7f, 0, 1, 0, -1, 0, 0, 0));
    foreach (rows[i]) begin
      send_item(rows[i].data_byte, rows[i].first, rows[i].last, rows[i].empty, 1);
      if (rows[i].nexp >= 0) begin
        if (step_codes.size() != rows[i].nexp || step_codes[0].code_byte != rows[i].b0 ||
            step_codes[1].code_byte != rows[i].b1 || step_codes[2].code_byte != rows[i].b2) begin
          $display("%0t: table row %0d disagrees with predictor", $time, i);
          errors++;
        end
      end
    end
    wait_drained();

    // random strips, mostly small alphabets so the dictionary gets hits
    while (items < 120) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1, 1);
      end else begin
        len = $urandom_range(1, 20);
        alpha = $urandom_range(0, 3) == 0 ? 8'hff : 8'h03;
        for (int k = 0; k < len; k++)
          send_item(8'($urandom) & (k % 7 == 6 ? 8'hff : alpha) ^
                    ($urandom_range(0, 1) ? 8'h00 : 8'hf0), k == 0,
                    k == len - 1 && $urandom_range(0, 5) != 0, 0, 1);
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    // tail with no idling
    sink_idle_on = 0;
    for (int k = 0; k < 12; k++)
      send_item(8'($urandom), k == 0, k == 11, 0, 0);
    wait_drained();
    repeat (50) @(posedge clk);

    $display("covered %0d items in %0d strips, %0d code bytes checked", items, strips, outs);
    $display("including empty strips, restarts, one-byte strips and dictionary hits");
    if (errors == 0 && exp_codes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
